// File: rtl/core/tlrxd_pkg.sv
package tlrxd_pkg;

   localparam int ROW_STRIDE_DEF = 64;

   localparam logic [7:0]  CMD_LITERAL = 8'hC0;
   localparam logic [7:0]  CMD_REPEAT  = 8'h80;
   localparam logic [13:0] ZP_MAX      = 14'h3FFF;

   localparam logic [1:0] REG_LAYER_COUNT   = 2'd0;
   localparam logic [1:0] REG_WIDTH_CHUNKS  = 2'd1;
   localparam logic [1:0] REG_HEIGHT_CHUNKS = 2'd2;
   localparam logic [1:0] REG_TOTAL_ROWS    = 2'd3;

   localparam logic [2:0] RST_LAYER_COUNT   = 3'd2;
   localparam logic [6:0] RST_WIDTH_CHUNKS  = 7'd64;
   localparam logic [7:0] RST_HEIGHT_CHUNKS = 8'd1;
   localparam logic [7:0] RST_TOTAL_ROWS    = 8'd0;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PLAN,
      S_ZERO,
      S_RD,
      S_PAIR,
      S_OVR,
      S_PAD,
      S_FILL
   } state_type;

   typedef enum logic [1:0] {
      PH_CMD,
      PH_B0,
      PH_B1,
      PH_B2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_ZERO,
      KIND_REPEAT,
      KIND_LITERAL
   } kind_type;

   typedef struct packed {
      logic clip;
      logic pad;
      logic fill;
      logic row_end;
      logic layer_end;
      logic wrap;
   } plan_type;

endpackage

// File: rtl/core/tile_layer_rle_xor_decoder.sv
// Tile-layer RLE/XOR decoder.
// req_* takes the compressed map one byte per transaction. rsp_* gives one
// transaction per tile pair, per first-row zero run, per row padding, per trailing fill
// and per overrun marker; tlast closes the transactions caused by one byte.
// csr_* is an APB-style port for layer_count, width_chunks, height_chunks and
// total_rows at byte addresses 0, 4, 8 and 12; write it only while idle.
// Data bytes of a pair and repeat or literal command bytes are taken without
// leaving idle. A zero-run command or a final pair byte passes through a planning
// state, then a line-store read and an emit per decoded or copied pair, a
// store write per entry cleared by a first-row zero run or by row padding, and
// an emit per overrun marker or trailing fill. The one read port of the line
// store is read for each pair before its emit. req_tready is low while a byte
// is being worked off.
// A result waits in an output register; while the receiver stalls, the
// sequencer holds at its next emit; bytes are still taken while it is idle.
// Reset (synchronous, active high) returns to the first row of layer 0 and
// restores the register defaults; line-store contents are kept and are
// written by the first row of each layer before any later row reads them.
module tile_layer_rle_xor_decoder #(
   parameter int ROW_STRIDE = tlrxd_pkg::ROW_STRIDE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // code_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // tile_first, tile_second, zero_pairs, layer_slot, row_index
   output logic [1:0]  rsp_tuser,   // overrun, map_done
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   import tlrxd_pkg::*;

   localparam int SLOTS  = ROW_STRIDE / 2;
   localparam int COL_W  = $clog2(SLOTS + 1);
   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CMP_W  = (COL_W > 8) ? COL_W : 8;
   localparam int DBL_W  = (COL_W + 1 > 7) ? COL_W + 1 : 7;
   localparam logic [COL_W-1:0] SLOTS_C  = COL_W'(SLOTS);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(SLOTS - 1);

   // configuration
   logic [2:0] layer_count_ff;
   logic [6:0] width_ff;
   logic [7:0] height_ff;
   logic [7:0] total_ff;
   logic       csr_wr;

   // sequencer and position
   state_type  state_ff, state_in;
   phase_type  phase_ff, phase_in;
   kind_type   kind_ff, kind_in;
   logic [6:0] left_ff, left_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [COL_W-1:0] cnt_ff, cnt_in;
   logic [7:0] row_ff, row_in;
   logic [1:0] layer_ff, layer_in;
   logic       sent_ff, sent_in;
   plan_type   plan_ff, plan_in;
   logic [13:0] fill_zp_ff, fill_zp_in;

   // payload
   logic [7:0]  cmd_ff, cmd_in;
   logic [15:0] bc_ff, bc_in;
   logic [23:0] pair_ff, pair_in;

   // output register
   logic        out_valid_ff, out_valid_in;
   logic [47:0] out_data_ff, out_data_in;
   logic [1:0]  out_user_ff, out_user_in;
   logic        out_last_ff, out_last_in;

   // line store
   logic             mem_we;
   logic [23:0]      mem_wdata;
   logic             mem_re;
   logic [23:0]      mem_rdata;

   // planning
   logic [CMP_W-1:0] n_pl;
   logic [COL_W-1:0] avail_pl, take_pl, fc_pl;
   logic             end_pl;
   logic [8:0]       row1;
   logic [7:0]       height_eff;
   logic [2:0]       layers_eff;
   logic [7:0]       fill_diff;
   logic [15:0]      fill_prod;
   plan_type         plan_pl;

   // item build
   logic        accept;
   logic        slot_free;
   logic        emit;
   logic [11:0] it_first, it_second;
   logic [13:0] it_zp;
   logic [7:0]  it_row;
   logic        it_ov, it_last;
   logic [1:0]  layer_slot;
   logic [23:0] pair_val;
   logic        finish;
   state_type   after_run, after_ovr, after_pad;

   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_LAYER_COUNT:   csr_prdata = 32'(layer_count_ff);
         REG_WIDTH_CHUNKS:  csr_prdata = 32'(width_ff);
         REG_HEIGHT_CHUNKS: csr_prdata = 32'(height_ff);
         REG_TOTAL_ROWS:    csr_prdata = 32'(total_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_count_ff <= RST_LAYER_COUNT;
         width_ff       <= RST_WIDTH_CHUNKS;
         height_ff      <= RST_HEIGHT_CHUNKS;
         total_ff       <= RST_TOTAL_ROWS;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_LAYER_COUNT:   layer_count_ff <= csr_pwdata[2:0];
            REG_WIDTH_CHUNKS:  width_ff       <= csr_pwdata[6:0];
            REG_HEIGHT_CHUNKS: height_ff      <= csr_pwdata[7:0];
            REG_TOTAL_ROWS:    total_ff       <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   assign height_eff = (height_ff == 8'd0) ? 8'd1 : height_ff;
   assign layers_eff = (layer_count_ff == 3'd0) ? 3'd1 :
                       (layer_count_ff > 3'd4) ? 3'd4 : layer_count_ff;
   assign layer_slot = 2'(layers_eff - 3'd1 - {1'b0, layer_ff});
   assign row1       = {1'b0, row_ff} + 9'd1;

   always_comb begin
      unique case (kind_ff)
         KIND_ZERO:   n_pl = CMP_W'({1'b0, cmd_ff[6:0]}) + CMP_W'(1'b1);
         KIND_REPEAT: n_pl = CMP_W'(left_ff);
         default:     n_pl = CMP_W'(1'b1);
      endcase
      avail_pl  = SLOTS_C - col_ff;
      take_pl   = (n_pl > CMP_W'(avail_pl)) ? avail_pl : COL_W'(n_pl);
      fc_pl     = col_ff + take_pl;
      end_pl    = (kind_ff != KIND_LITERAL) || (left_ff == 7'd1);
      plan_pl.clip      = (n_pl > CMP_W'(avail_pl));
      plan_pl.row_end   = end_pl && ((DBL_W'({fc_pl, 1'b0}) >= DBL_W'(width_ff)) ||
                                     (fc_pl >= SLOTS_C));
      plan_pl.pad       = plan_pl.row_end && (fc_pl < SLOTS_C);
      plan_pl.layer_end = plan_pl.row_end && (row1 >= {1'b0, height_eff});
      plan_pl.fill      = plan_pl.layer_end && ({1'b0, total_ff} > row1);
      plan_pl.wrap      = plan_pl.layer_end && (({1'b0, layer_ff} + 3'd1) >= layers_eff);
      fill_diff = total_ff - row1[7:0];
      fill_prod = 16'(fill_diff) * 16'(SLOTS);
   end

   assign after_pad = plan_ff.fill ? S_FILL : S_IDLE;
   assign after_ovr = plan_ff.pad ? S_PAD : after_pad;
   assign after_run = plan_ff.clip ? S_OVR : after_ovr;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if ((phase_ff == PH_CMD && req_tdata < CMD_REPEAT) || phase_ff == PH_B2) begin
                  state_in = S_PLAN;
               end
            end
         end
         S_PLAN: begin
            if (take_pl == '0) begin
               state_in = S_OVR;
            end else if (kind_ff == KIND_ZERO && row_ff == 8'd0) begin
               state_in = S_ZERO;
            end else begin
               state_in = S_RD;
            end
         end
         S_ZERO: begin
            if ((sent_ff || slot_free) && cnt_ff == COL_W'(1'b1)) begin
               state_in = after_run;
            end
         end
         S_RD: state_in = S_PAIR;
         S_PAIR: begin
            if (slot_free) begin
               state_in = (cnt_ff == COL_W'(1'b1)) ? after_run : S_RD;
            end
         end
         S_OVR: begin
            if (slot_free) begin
               state_in = after_ovr;
            end
         end
         S_PAD: begin
            if ((sent_ff || slot_free) && col_ff == LAST_COL) begin
               state_in = after_pad;
            end
         end
         S_FILL: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign pair_val = (kind_ff == KIND_ZERO) ? mem_rdata :
                     (pair_ff ^ ((row_ff != 8'd0) ? mem_rdata : 24'd0));
   assign finish   = (state_ff != S_IDLE) && (state_in == S_IDLE);

   // datapath and outputs
   always_comb begin
      phase_in   = phase_ff;
      kind_in    = kind_ff;
      left_in    = left_ff;
      col_in     = col_ff;
      cnt_in     = cnt_ff;
      row_in     = row_ff;
      layer_in   = layer_ff;
      sent_in    = sent_ff;
      plan_in    = plan_ff;
      fill_zp_in = fill_zp_ff;
      cmd_in     = cmd_ff;
      bc_in      = bc_ff;
      pair_in    = pair_ff;
      emit       = 1'b0;
      it_first   = '0;
      it_second  = '0;
      it_zp      = '0;
      it_row     = row_ff;
      it_ov      = 1'b0;
      it_last    = 1'b0;
      mem_we     = 1'b0;
      mem_wdata  = '0;
      mem_re     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (phase_ff)
                  PH_CMD: begin
                     cmd_in = req_tdata;
                     if (req_tdata >= CMD_LITERAL) begin
                        kind_in  = KIND_LITERAL;
                        left_in  = {1'b0, req_tdata[5:0]} + 7'd1;
                        phase_in = PH_B0;
                     end else if (req_tdata >= CMD_REPEAT) begin
                        kind_in  = KIND_REPEAT;
                        left_in  = {1'b0, req_tdata[5:0]} + 7'd1;
                        phase_in = PH_B0;
                     end else begin
                        kind_in  = KIND_ZERO;
                     end
                  end
                  PH_B0: begin
                     bc_in    = {bc_ff[15:8], req_tdata};
                     phase_in = PH_B1;
                  end
                  PH_B1: begin
                     bc_in    = {req_tdata, bc_ff[7:0]};
                     phase_in = PH_B2;
                  end
                  PH_B2: begin
                     pair_in  = {req_tdata, bc_ff};
                  end
                  default: ;
               endcase
            end
         end
         S_PLAN: begin
            plan_in    = plan_pl;
            cnt_in     = take_pl;
            sent_in    = 1'b0;
            fill_zp_in = (fill_prod > 16'(ZP_MAX)) ? ZP_MAX : fill_prod[13:0];
            if (end_pl) begin
               phase_in = PH_CMD;
               left_in  = '0;
            end else begin
               phase_in = PH_B0;
               left_in  = left_ff - 7'd1;
            end
         end
         S_ZERO: begin
            if (sent_ff || slot_free) begin
               emit     = !sent_ff;
               it_zp    = 14'(cnt_ff);
               it_last  = !(plan_ff.clip || plan_ff.pad || plan_ff.fill);
               sent_in  = 1'b1;
               mem_we   = 1'b1;
               col_in   = col_ff + COL_W'(1'b1);
               cnt_in   = cnt_ff - COL_W'(1'b1);
               if (cnt_ff == COL_W'(1'b1)) begin
                  sent_in = 1'b0;
               end
            end
         end
         S_RD: begin
            mem_re = 1'b1;
         end
         S_PAIR: begin
            if (slot_free) begin
               emit      = 1'b1;
               it_first  = pair_val[11:0];
               it_second = pair_val[23:12];
               it_last   = (cnt_ff == COL_W'(1'b1)) &&
                           !(plan_ff.clip || plan_ff.pad || plan_ff.fill);
               mem_we    = (kind_ff != KIND_ZERO);
               mem_wdata = pair_val;
               col_in    = col_ff + COL_W'(1'b1);
               cnt_in    = cnt_ff - COL_W'(1'b1);
            end
         end
         S_OVR: begin
            if (slot_free) begin
               emit    = 1'b1;
               it_ov   = 1'b1;
               it_last = !(plan_ff.pad || plan_ff.fill);
            end
         end
         S_PAD: begin
            if (sent_ff || slot_free) begin
               emit    = !sent_ff;
               it_zp   = 14'(SLOTS_C - col_ff);
               it_last = !plan_ff.fill;
               sent_in = 1'b1;
               mem_we  = 1'b1;
               col_in  = col_ff + COL_W'(1'b1);
               if (col_ff == LAST_COL) begin
                  sent_in = 1'b0;
               end
            end
         end
         S_FILL: begin
            if (slot_free) begin
               emit    = 1'b1;
               it_zp   = fill_zp_ff;
               it_row  = row1[7:0];
               it_last = 1'b1;
            end
         end
         default: ;
      endcase

      if (finish && plan_ff.row_end) begin
         col_in = '0;
         if (plan_ff.layer_end) begin
            row_in   = '0;
            layer_in = plan_ff.wrap ? 2'd0 : layer_ff + 2'd1;
         end else begin
            row_in   = row1[7:0];
         end
      end

      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_user_in  = out_user_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_data_in  = {it_row, layer_slot, it_zp, it_second, it_first};
         out_user_in  = {it_last && plan_ff.wrap, it_ov};
         out_last_in  = it_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_CMD;
         kind_ff      <= KIND_ZERO;
         left_ff      <= '0;
         col_ff       <= '0;
         cnt_ff       <= '0;
         row_ff       <= '0;
         layer_ff     <= '0;
         sent_ff      <= 1'b0;
         plan_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         kind_ff      <= kind_in;
         left_ff      <= left_in;
         col_ff       <= col_in;
         cnt_ff       <= cnt_in;
         row_ff       <= row_in;
         layer_ff     <= layer_in;
         sent_ff      <= sent_in;
         plan_ff      <= plan_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_zp_ff  <= fill_zp_in;
      cmd_ff      <= cmd_in;
      bc_ff       <= bc_in;
      pair_ff     <= pair_in;
      out_data_ff <= out_data_in;
      out_user_ff <= out_user_in;
      out_last_ff <= out_last_in;
   end

   tlrxd_ram #(
      .WIDTH (24),
      .DEPTH (SLOTS)
   ) u_line_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (col_ff[IDX_W-1:0]),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (col_ff[IDX_W-1:0]),
      .rdata (mem_rdata)
   );

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mem_we)
      else $error("line store written while idle");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= SLOTS_C)
      else $error("column beyond row stride");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> rsp_tlast)
      else $error("map_done on a transaction that is not last");

   a_pair_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PAIR && !slot_free) |=> (state_ff == S_PAIR && $stable(col_ff)))
      else $error("pair advanced while output stalled");

endmodule

// File: rtl/core/tlrxd_ram.sv
module tlrxd_ram #(
   parameter int WIDTH  = 24,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
